[rtl/shs_pkg.sv]
// shared types, constants and round functions of the sha-256 stream hasher
package shs_pkg;

	typedef logic [31:0] word_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	localparam int BLOCK_BYTES = 64;
	localparam int LENGTH_POS  = 56;
	localparam int ROUNDS      = 64;
	localparam int HASH_WORDS  = 8;
	localparam logic [7:0] PAD_MARK = 8'h80;

	// round constants
	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// initial hash values
	localparam word_t INIT_HASH [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// rotate right by a constant amount
	function automatic word_t ror32(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

endpackage

[rtl/sha256_stream_hasher_unit.sv]
// sha-256 stream hasher: byte gathering, padding, iterative compression, digest output
//
// channel   dir  tdata               tuser        tlast
// s_axis    in   data_byte [7:0]     byte_valid   end_of_message
// m_axis    out  digest_word [31:0]  -            last_word
//
// a byte beat is taken every cycle while the block fills; the 64th byte starts the
// compression, which runs one round per cycle on a single round unit through all 64
// rounds and then adds the working variables into the chain value in ST_FINAL.
// on the end beat the padding is shifted in one byte per cycle up to the block end,
// then one or two compressions follow and the eight digest beats go out.
// reset clears control, bit count and fill count and loads the initial hash values.
// a stalled digest beat holds its word; no input beat is taken until all eight are gone.
module sha256_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte [7:0]
	input  logic        s_axis_tuser,   // byte_valid [0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // digest_word [31:0]
	output logic        m_axis_tlast
);

	localparam logic [5:0] LAST_FILL  = 6'(shs_pkg::BLOCK_BYTES - 1);
	localparam logic [5:0] LEN_FILL   = 6'(shs_pkg::LENGTH_POS);
	localparam logic [5:0] LAST_ROUND = 6'(shs_pkg::ROUNDS - 1);
	localparam logic [2:0] LAST_OUT   = 3'(shs_pkg::HASH_WORDS - 1);

	shs_pkg::state_t state_q, state_d;

	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [511:0] blk_q;
	shs_pkg::word_t h_q [shs_pkg::HASH_WORDS];
	shs_pkg::word_t v_q [shs_pkg::HASH_WORDS];
	logic [5:0]   rnd_q;
	logic [2:0]   oidx_q;
	logic         closing_q;
	logic         mark_q;
	logic         len_ok_q;
	logic         fin_q;

	logic         in_acc;
	logic         out_acc;
	logic         shift_en;
	logic [7:0]   shift_byte;
	logic [7:0]   pad_byte;
	logic [63:0]  len_shift;
	logic         block_full;
	logic         place_mark;

	shs_pkg::word_t w_cur, w_new, t1, t2;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// padding byte: mark first, then zeros, then the big-endian bit length
	assign len_shift  = bits_q >> {3'd7 - fill_q[2:0], 3'b000};
	assign place_mark = (state_q == shs_pkg::ST_PAD) && !mark_q;
	always_comb begin
		if (!mark_q) begin
			pad_byte = shs_pkg::PAD_MARK;
		end else if (len_ok_q && (fill_q >= LEN_FILL)) begin
			pad_byte = len_shift[7:0];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// byte shifter into the block register
	assign shift_en   = (in_acc && s_axis_tuser) || (state_q == shs_pkg::ST_PAD);
	assign shift_byte = (state_q == shs_pkg::ST_PAD) ? pad_byte : s_axis_tdata;
	assign block_full = shift_en && (fill_q == LAST_FILL);

	// round unit and schedule word, window word 0 is w[t]
	assign w_cur = blk_q[511:480];
	assign w_new = w_cur + shs_pkg::small_sigma0(blk_q[479:448]) + blk_q[223:192]
		+ shs_pkg::small_sigma1(blk_q[63:32]);
	assign t1 = v_q[7] + shs_pkg::big_sigma1(v_q[4])
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + shs_pkg::ROUND_K[rnd_q] + w_cur;
	assign t2 = shs_pkg::big_sigma0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		m_axis_tlast  = 1'b0;
		unique case (state_q)
			shs_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_acc) begin
					if (block_full) begin
						state_d = shs_pkg::ST_ROUND;
					end else if (s_axis_tlast) begin
						state_d = shs_pkg::ST_PAD;
					end
				end
			end
			shs_pkg::ST_PAD: begin
				if (block_full) begin
					state_d = shs_pkg::ST_ROUND;
				end
			end
			shs_pkg::ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = shs_pkg::ST_FINAL;
				end
			end
			shs_pkg::ST_FINAL: begin
				if (fin_q) begin
					state_d = shs_pkg::ST_OUT;
				end else if (closing_q) begin
					state_d = shs_pkg::ST_PAD;
				end else begin
					state_d = shs_pkg::ST_IDLE;
				end
			end
			shs_pkg::ST_OUT: begin
				m_axis_tvalid = 1'b1;
				m_axis_tlast  = (oidx_q == LAST_OUT);
				if (out_acc && (oidx_q == LAST_OUT)) begin
					state_d = shs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = shs_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_axis_tdata = h_q[oidx_q];

	// control, counters, bit count and chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			bits_q    <= '0;
			rnd_q     <= '0;
			oidx_q    <= '0;
			closing_q <= 1'b0;
			mark_q    <= 1'b0;
			len_ok_q  <= 1'b0;
			fin_q     <= 1'b0;
			for (int i = 0; i < shs_pkg::HASH_WORDS; i++) begin
				h_q[i] <= shs_pkg::INIT_HASH[i];
			end
		end else begin
			// byte count within the block
			if (shift_en) begin
				fill_q <= block_full ? '0 : fill_q + 6'd1;
			end
			if (in_acc && s_axis_tuser) begin
				bits_q <= bits_q + 64'd8;
			end
			if (in_acc && s_axis_tlast) begin
				closing_q <= 1'b1;
			end
			// length may follow only if the mark landed ahead of the length field
			if (place_mark) begin
				mark_q   <= 1'b1;
				len_ok_q <= (fill_q < LEN_FILL);
			end
			if (block_full) begin
				fin_q <= (state_q == shs_pkg::ST_PAD) && mark_q && len_ok_q;
				rnd_q <= '0;
			end else if (state_q == shs_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			// chain update after the last round
			if (state_q == shs_pkg::ST_FINAL) begin
				for (int i = 0; i < shs_pkg::HASH_WORDS; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
				if (mark_q) begin
					len_ok_q <= 1'b1;
				end
			end
			// digest beats, then back to a fresh message
			if (out_acc) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == LAST_OUT) begin
					bits_q    <= '0;
					fill_q    <= '0;
					closing_q <= 1'b0;
					mark_q    <= 1'b0;
					len_ok_q  <= 1'b0;
					fin_q     <= 1'b0;
					for (int i = 0; i < shs_pkg::HASH_WORDS; i++) begin
						h_q[i] <= shs_pkg::INIT_HASH[i];
					end
				end
			end
		end
	end

	// block register and working variables
	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= {blk_q[503:0], shift_byte};
		end else if (state_q == shs_pkg::ST_ROUND) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (block_full) begin
			for (int i = 0; i < shs_pkg::HASH_WORDS; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == shs_pkg::ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// input and digest output never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while digest beat pending");

	// a filled block stops input for the compression
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tuser && (fill_q == LAST_FILL)) |=> !s_axis_tready)
		else $error("input taken during compression");

	// last digest beat returns to a fresh message
	a_done_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_axis_tlast) |=> (s_axis_tready && (bits_q == 64'd0) && (fill_q == 6'd0)))
		else $error("state not restored after digest");

	// digest only after a compression that carried the length
	a_out_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == shs_pkg::ST_FINAL) && $past(fin_q))
		else $error("digest output without final block");

endmodule
